FILE: rtl/core/mscs_pkg.sv
// Shared types, widths and segment tables for the marching-squares cell block.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package mscs_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int FRAC_W      = 16;
    localparam int IDX_W       = 12;
    localparam int ORG_W       = 12;
    localparam int SIZE_W      = 20;
    localparam int SIZE_FRAC_W = 8;
    localparam int PIX_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam int QUEUE_DEPTH = 32;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // position = (index << FRAC_W) + fraction, index up to 2^IDX_W
    localparam int POS_W  = IDX_W + 1 + FRAC_W;
    localparam int PROD_W = POS_W + SIZE_W;
    localparam int RND_SH = FRAC_W + SIZE_FRAC_W;
    localparam int RES_W  = PROD_W + 1 - RND_SH;
    localparam int SUM_W  = RES_W + 1;

    localparam logic [FRAC_W:0] FRAC_ONE  = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [FRAC_W:0] FRAC_HALF = {2'b01, {(FRAC_W - 1){1'b0}}};
    localparam logic [PIX_W-1:0] PIX_MAX  = {PIX_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ISO_LEVEL   = 3'd0,
        CFG_ORIGIN_X    = 3'd1,
        CFG_ORIGIN_Y    = 3'd2,
        CFG_CELL_WIDTH  = 3'd3,
        CFG_CELL_HEIGHT = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        EDGE_TOP    = 2'd0,
        EDGE_RIGHT  = 2'd1,
        EDGE_BOTTOM = 2'd2,
        EDGE_LEFT   = 2'd3
    } edge_t;

    // one edge inside the fraction divider
    typedef struct packed {
        logic [SAMPLE_W-1:0] rem;
        logic [SAMPLE_W-1:0] den;
        logic [FRAC_W-1:0]   quo;
        logic                fixed;
        logic [FRAC_W:0]     fixed_val;
    } div_t;

    typedef struct packed {
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic [3:0]       case_code;
        logic             keep;
    } side_t;

    typedef struct packed {
        logic [3:0]            case_code;
        logic [3:0][PIX_W-1:0] px;
        logic [3:0][PIX_W-1:0] py;
    } cell_rec_t;

    typedef struct packed {
        logic valid;
        logic keep;
    } front_ctrl_t;

    function automatic logic is_saddle(input logic [3:0] c);
        return (c == 4'd5) || (c == 4'd10);
    endfunction

    function automatic edge_t seg_start(input logic [3:0] c, input logic second);
        edge_t e;
        if (second)
        begin
            e = (c == 4'd5) ? EDGE_RIGHT : EDGE_LEFT;
        end
        else
        begin
            case (c) inside
                4'd1, 4'd14, 4'd3, 4'd12, 4'd7, 4'd8, 4'd5: e = EDGE_LEFT;
                4'd4, 4'd11:                                 e = EDGE_RIGHT;
                default:                                     e = EDGE_TOP;
            endcase
        end
        return e;
    endfunction

    function automatic edge_t seg_end(input logic [3:0] c, input logic second);
        edge_t e;
        if (second)
        begin
            e = EDGE_BOTTOM;
        end
        else
        begin
            case (c) inside
                4'd1, 4'd14, 4'd5:                 e = EDGE_TOP;
                4'd2, 4'd13, 4'd10, 4'd3, 4'd12:   e = EDGE_RIGHT;
                default:                           e = EDGE_BOTTOM;
            endcase
        end
        return e;
    endfunction

endpackage

FILE: rtl/core/mscs_div.sv
// Pipelined restoring divider for one edge crossing fraction, one quotient bit per stage.
// Depends on mscs_pkg.
module mscs_div (
    input  logic                        clk,
    input  mscs_pkg::div_t              din,
    output logic [mscs_pkg::FRAC_W:0]   frac
);

    mscs_pkg::div_t st_reg [mscs_pkg::FRAC_W];

    function automatic mscs_pkg::div_t step(input mscs_pkg::div_t s);
        mscs_pkg::div_t o;
        logic [mscs_pkg::SAMPLE_W:0] sh;
        logic b;
        o  = s;
        sh = {s.rem, 1'b0};
        b  = (sh >= {1'b0, s.den});
        if (b)
        begin
            o.rem = mscs_pkg::SAMPLE_W'(sh - {1'b0, s.den});
        end
        else
        begin
            o.rem = sh[mscs_pkg::SAMPLE_W-1:0];
        end
        o.quo = {s.quo[mscs_pkg::FRAC_W-2:0], b};
        return o;
    endfunction

    always_ff @(posedge clk)
    begin
        st_reg[0] <= step(din);
    end

    for (genvar i = 1; i < mscs_pkg::FRAC_W; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            st_reg[i] <= step(st_reg[i-1]);
        end
    end

    assign frac = st_reg[mscs_pkg::FRAC_W-1].fixed ? st_reg[mscs_pkg::FRAC_W-1].fixed_val
                                                   : {1'b0, st_reg[mscs_pkg::FRAC_W-1].quo};

endmodule

FILE: rtl/core/mscs_front.sv
// Front end: classifies each cell, divides the crossing on each cell edge and maps it to pixels.
// Non-stalling pipeline; depends on mscs_pkg and mscs_div.
module mscs_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic [mscs_pkg::IDX_W-1:0]           cell_col,
    input  logic [mscs_pkg::IDX_W-1:0]           cell_row,
    input  logic signed [mscs_pkg::SAMPLE_W-1:0] top_left,
    input  logic signed [mscs_pkg::SAMPLE_W-1:0] top_right,
    input  logic signed [mscs_pkg::SAMPLE_W-1:0] bottom_left,
    input  logic signed [mscs_pkg::SAMPLE_W-1:0] bottom_right,
    input  logic [3:0]                           missing_mask,
    input  logic signed [mscs_pkg::SAMPLE_W-1:0] iso_level,
    input  logic [mscs_pkg::ORG_W-1:0]           origin_x,
    input  logic [mscs_pkg::ORG_W-1:0]           origin_y,
    input  logic [mscs_pkg::SIZE_W-1:0]          cell_width,
    input  logic [mscs_pkg::SIZE_W-1:0]          cell_height,
    output mscs_pkg::front_ctrl_t                ctrl,
    output mscs_pkg::cell_rec_t                  rec
);

    localparam int FW = mscs_pkg::FRAC_W;
    localparam int SW = mscs_pkg::SAMPLE_W;
    localparam logic [mscs_pkg::PROD_W:0] ROUND_ADD =
        {{(mscs_pkg::PROD_W - mscs_pkg::RND_SH + 1){1'b0}}, 1'b1,
         {(mscs_pkg::RND_SH - 1){1'b0}}};

    mscs_pkg::div_t  prep_reg [4];
    mscs_pkg::side_t side_reg [FW+1];
    logic            vld_reg  [FW+1];
    logic [FW:0]     frac [4];

    logic [mscs_pkg::PROD_W-1:0] mx_reg [4];
    logic [mscs_pkg::PROD_W-1:0] my_reg [4];
    mscs_pkg::side_t             mside_reg;
    logic                        mvld_reg;
    mscs_pkg::cell_rec_t         rec_reg;
    mscs_pkg::front_ctrl_t       ctrl_reg;

    logic [3:0] case_code;

    function automatic mscs_pkg::div_t prep(input logic signed [SW-1:0] a,
                                            input logic signed [SW-1:0] b,
                                            input logic signed [SW-1:0] lv);
        mscs_pkg::div_t r;
        logic signed [SW:0] d;
        logic signed [SW:0] n;
        logic signed [SW:0] dm;
        logic signed [SW:0] nm;
        d  = {b[SW-1], b} - {a[SW-1], a};
        n  = {lv[SW-1], lv} - {a[SW-1], a};
        dm = d[SW] ? -d : d;
        nm = d[SW] ? -n : n;
        r  = '0;
        if (d == '0)
        begin
            r.fixed     = 1'b1;
            r.fixed_val = mscs_pkg::FRAC_HALF;
        end
        else if (nm[SW] || (nm == '0))
        begin
            r.fixed     = 1'b1;
            r.fixed_val = '0;
        end
        else if (nm >= dm)
        begin
            r.fixed     = 1'b1;
            r.fixed_val = mscs_pkg::FRAC_ONE;
        end
        else
        begin
            r.rem = nm[SW-1:0];
            r.den = dm[SW-1:0];
        end
        return r;
    endfunction

    function automatic logic [mscs_pkg::POS_W-1:0] pos_of(input logic [mscs_pkg::IDX_W:0] idx,
                                                          input logic [FW:0] f);
        return {idx, {FW{1'b0}}} + mscs_pkg::POS_W'(f);
    endfunction

    function automatic logic [mscs_pkg::PIX_W-1:0] to_pix(
        input logic [mscs_pkg::PROD_W-1:0] p,
        input logic [mscs_pkg::ORG_W-1:0]  org);
        logic [mscs_pkg::PROD_W:0] t;
        logic [mscs_pkg::SUM_W-1:0] s;
        t = {1'b0, p} + ROUND_ADD;
        s = {1'b0, t[mscs_pkg::PROD_W:mscs_pkg::RND_SH]} + mscs_pkg::SUM_W'(org);
        return (s > mscs_pkg::SUM_W'(mscs_pkg::PIX_MAX)) ? mscs_pkg::PIX_MAX
                                                         : s[mscs_pkg::PIX_W-1:0];
    endfunction

    assign case_code = {bottom_left >= iso_level, bottom_right >= iso_level,
                        top_right >= iso_level, top_left >= iso_level};

    always_ff @(posedge clk)
    begin
        prep_reg[mscs_pkg::EDGE_TOP]    <= prep(top_left, top_right, iso_level);
        prep_reg[mscs_pkg::EDGE_RIGHT]  <= prep(top_right, bottom_right, iso_level);
        prep_reg[mscs_pkg::EDGE_BOTTOM] <= prep(bottom_left, bottom_right, iso_level);
        prep_reg[mscs_pkg::EDGE_LEFT]   <= prep(top_left, bottom_left, iso_level);
        side_reg[0].col       <= cell_col;
        side_reg[0].row       <= cell_row;
        side_reg[0].case_code <= case_code;
        side_reg[0].keep      <= (missing_mask == 4'd0) && (case_code != 4'd0)
                                 && (case_code != 4'd15);
        for (int i = 1; i <= FW; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= FW; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            mvld_reg <= 1'b0;
            ctrl_reg <= '0;
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int i = 1; i <= FW; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            mvld_reg       <= vld_reg[FW];
            ctrl_reg.valid <= mvld_reg;
            ctrl_reg.keep  <= mside_reg.keep;
        end
    end

    for (genvar e = 0; e < 4; e++)
    begin : g_edge
        mscs_div u_div (
            .clk  (clk),
            .din  (prep_reg[e]),
            .frac (frac[e])
        );
    end

    // one multiplier per edge and coordinate; the coordinate fixed by the edge uses a zero fraction
    always_ff @(posedge clk)
    begin
        mside_reg <= side_reg[FW];
        mx_reg[mscs_pkg::EDGE_TOP]    <= pos_of({1'b0, side_reg[FW].col},
                                                frac[mscs_pkg::EDGE_TOP]) * cell_width;
        my_reg[mscs_pkg::EDGE_TOP]    <= pos_of({1'b0, side_reg[FW].row}, '0) * cell_height;
        mx_reg[mscs_pkg::EDGE_RIGHT]  <= pos_of({1'b0, side_reg[FW].col} + 1'b1, '0)
                                         * cell_width;
        my_reg[mscs_pkg::EDGE_RIGHT]  <= pos_of({1'b0, side_reg[FW].row},
                                                frac[mscs_pkg::EDGE_RIGHT]) * cell_height;
        mx_reg[mscs_pkg::EDGE_BOTTOM] <= pos_of({1'b0, side_reg[FW].col},
                                                frac[mscs_pkg::EDGE_BOTTOM]) * cell_width;
        my_reg[mscs_pkg::EDGE_BOTTOM] <= pos_of({1'b0, side_reg[FW].row} + 1'b1, '0)
                                         * cell_height;
        mx_reg[mscs_pkg::EDGE_LEFT]   <= pos_of({1'b0, side_reg[FW].col}, '0) * cell_width;
        my_reg[mscs_pkg::EDGE_LEFT]   <= pos_of({1'b0, side_reg[FW].row},
                                                frac[mscs_pkg::EDGE_LEFT]) * cell_height;
    end

    always_ff @(posedge clk)
    begin
        rec_reg.case_code <= mside_reg.case_code;
        for (int e = 0; e < 4; e++)
        begin
            rec_reg.px[e] <= to_pix(mx_reg[e], origin_x);
            rec_reg.py[e] <= to_pix(my_reg[e], origin_y);
        end
    end

    assign ctrl = ctrl_reg;
    assign rec  = rec_reg;

endmodule

FILE: rtl/core/mscs_queue.sv
// Cell record queue between the front pipeline and the segment back end.
// Depends on mscs_pkg; occupancy is bounded by the credit counter at the top level.
module mscs_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  mscs_pkg::cell_rec_t wr_rec,
    input  logic                rd_en,
    output mscs_pkg::cell_rec_t head,
    output logic                head_valid
);

    mscs_pkg::cell_rec_t         mem_reg [mscs_pkg::QUEUE_DEPTH];
    logic [mscs_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [mscs_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [mscs_pkg::QCNT_W-1:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + mscs_pkg::QCNT_W'(wr_en) - mscs_pkg::QCNT_W'(rd_en);
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (cnt_reg != '0);

endmodule

FILE: rtl/core/mscs_back.sv
// Back end: expands each queued cell into one or two segments in an output register.
// Depends on mscs_pkg.
module mscs_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mscs_pkg::cell_rec_t          head,
    input  logic                         head_valid,
    output logic                         head_pop,
    input  logic                         pop,
    output logic                         empty,
    output logic [mscs_pkg::PIX_W-1:0]   start_x,
    output logic [mscs_pkg::PIX_W-1:0]   start_y,
    output logic [mscs_pkg::PIX_W-1:0]   end_x,
    output logic [mscs_pkg::PIX_W-1:0]   end_y,
    output logic                         last_segment
);

    logic                       out_valid_reg;
    logic                       second_reg;
    logic [mscs_pkg::PIX_W-1:0] sx_reg;
    logic [mscs_pkg::PIX_W-1:0] sy_reg;
    logic [mscs_pkg::PIX_W-1:0] ex_reg;
    logic [mscs_pkg::PIX_W-1:0] ey_reg;
    logic                       last_reg;

    logic           load;
    logic           last;
    mscs_pkg::edge_t s_edge;
    mscs_pkg::edge_t e_edge;

    assign load     = !out_valid_reg || pop;
    assign last     = second_reg || !mscs_pkg::is_saddle(head.case_code);
    assign head_pop = load && head_valid && last;
    assign s_edge   = mscs_pkg::seg_start(head.case_code, second_reg);
    assign e_edge   = mscs_pkg::seg_end(head.case_code, second_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= head_valid;
            if (head_valid)
            begin
                second_reg <= !last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            sx_reg   <= head.px[s_edge];
            sy_reg   <= head.py[s_edge];
            ex_reg   <= head.px[e_edge];
            ey_reg   <= head.py[e_edge];
            last_reg <= last;
        end
    end

    assign empty        = !out_valid_reg;
    assign start_x      = sx_reg;
    assign start_y      = sy_reg;
    assign end_x        = ex_reg;
    assign end_y        = ey_reg;
    assign last_segment = last_reg;

endmodule

FILE: rtl/core/marching_squares_cell_segments.sv
// Marching-squares isoline cell: one cell per beat in, zero to two segments out.
// From the accepting edge to the first segment a cell passes the prep registers, then 16
// divider stages, multiply, pixel, queue write and output register, plus any queue wait.
// One cell per cycle unless full, one segment per cycle while popped; saddle cells give two.
// Reset: asynchronous, clears pipeline valids, queue and credits; config registers take defaults.
module marching_squares_cell_segments (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [mscs_pkg::IDX_W-1:0]           cell_col,
    input  logic [mscs_pkg::IDX_W-1:0]           cell_row,
    input  logic signed [mscs_pkg::SAMPLE_W-1:0] top_left,
    input  logic signed [mscs_pkg::SAMPLE_W-1:0] top_right,
    input  logic signed [mscs_pkg::SAMPLE_W-1:0] bottom_left,
    input  logic signed [mscs_pkg::SAMPLE_W-1:0] bottom_right,
    input  logic [3:0]                           missing_mask,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [mscs_pkg::PIX_W-1:0]           start_x,
    output logic [mscs_pkg::PIX_W-1:0]           start_y,
    output logic [mscs_pkg::PIX_W-1:0]           end_x,
    output logic [mscs_pkg::PIX_W-1:0]           end_y,
    output logic                                 last_segment,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mscs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mscs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic signed [mscs_pkg::SAMPLE_W-1:0] iso_level_reg;
    logic [mscs_pkg::ORG_W-1:0]           origin_x_reg;
    logic [mscs_pkg::ORG_W-1:0]           origin_y_reg;
    logic [mscs_pkg::SIZE_W-1:0]          cell_width_reg;
    logic [mscs_pkg::SIZE_W-1:0]          cell_height_reg;
    logic [mscs_pkg::QCNT_W-1:0]          credit_reg;
    logic [mscs_pkg::QCNT_W-1:0]          credit_next;

    logic                  accept;
    logic                  q_wr;
    logic                  q_pop;
    logic                  dropped;
    logic                  head_valid;
    mscs_pkg::front_ctrl_t fctrl;
    mscs_pkg::cell_rec_t   frec;
    mscs_pkg::cell_rec_t   head;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;
    // a credit covers a cell from accept until it leaves the queue or is dropped
    assign full      = (credit_reg == mscs_pkg::QCNT_W'(mscs_pkg::QUEUE_DEPTH));
    assign q_wr      = fctrl.valid && fctrl.keep;
    assign dropped   = fctrl.valid && !fctrl.keep;

    always_comb
    begin
        credit_next = credit_reg + mscs_pkg::QCNT_W'(accept)
                      - mscs_pkg::QCNT_W'(dropped) - mscs_pkg::QCNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iso_level_reg   <= '0;
            origin_x_reg    <= mscs_pkg::ORG_W'(30);
            origin_y_reg    <= mscs_pkg::ORG_W'(12);
            cell_width_reg  <= mscs_pkg::SIZE_W'(256);
            cell_height_reg <= mscs_pkg::SIZE_W'(256);
            credit_reg      <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mscs_pkg::CFG_ISO_LEVEL:   iso_level_reg   <= cfg_data[mscs_pkg::SAMPLE_W-1:0];
                    mscs_pkg::CFG_ORIGIN_X:    origin_x_reg    <= cfg_data[mscs_pkg::ORG_W-1:0];
                    mscs_pkg::CFG_ORIGIN_Y:    origin_y_reg    <= cfg_data[mscs_pkg::ORG_W-1:0];
                    mscs_pkg::CFG_CELL_WIDTH:  cell_width_reg  <= cfg_data[mscs_pkg::SIZE_W-1:0];
                    mscs_pkg::CFG_CELL_HEIGHT: cell_height_reg <= cfg_data[mscs_pkg::SIZE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    mscs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .cell_col     (cell_col),
        .cell_row     (cell_row),
        .top_left     (top_left),
        .top_right    (top_right),
        .bottom_left  (bottom_left),
        .bottom_right (bottom_right),
        .missing_mask (missing_mask),
        .iso_level    (iso_level_reg),
        .origin_x     (origin_x_reg),
        .origin_y     (origin_y_reg),
        .cell_width   (cell_width_reg),
        .cell_height  (cell_height_reg),
        .ctrl         (fctrl),
        .rec          (frec)
    );

    mscs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (q_wr),
        .wr_rec     (frec),
        .rd_en      (q_pop),
        .head       (head),
        .head_valid (head_valid)
    );

    mscs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .head_pop     (q_pop),
        .pop          (pop),
        .empty        (empty),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .last_segment (last_segment)
    );

endmodule

FILE: rtl/core/mscs_checker.sv
// Port-level checks for marching_squares_cell_segments, attached by bind.
// Depends on mscs_pkg for widths.
module mscs_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input logic [mscs_pkg::PIX_W-1:0] start_x,
    input logic [mscs_pkg::PIX_W-1:0] end_y,
    input logic                       last_segment
);

    // a waiting beat stays until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result beat dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(start_x) && $stable(end_y) && $stable(last_segment)))
        else $error("result payload changed while stalled");

    // second segment of a saddle cell follows right away
    a_saddle: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_segment) |=> !empty)
        else $error("second segment of a cell not ready");

    a_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> (!full && empty))
        else $error("block not idle after reset");

endmodule

bind marching_squares_cell_segments mscs_checker u_mscs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .start_x      (start_x),
    .end_y        (end_y),
    .last_segment (last_segment)
);

FILE: verif/marching_squares_cell_segments_chk.sv
// Checker for the marching-squares cell block: tracks config writes, predicts segments
// per accepted cell and compares every popped segment. Depends on mscs_pkg only.
module marching_squares_cell_segments_chk (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic                                 full,
    input  logic [mscs_pkg::IDX_W-1:0]           cell_col,
    input  logic [mscs_pkg::IDX_W-1:0]           cell_row,
    input  logic signed [mscs_pkg::SAMPLE_W-1:0] top_left,
    input  logic signed [mscs_pkg::SAMPLE_W-1:0] top_right,
    input  logic signed [mscs_pkg::SAMPLE_W-1:0] bottom_left,
    input  logic signed [mscs_pkg::SAMPLE_W-1:0] bottom_right,
    input  logic [3:0]                           missing_mask,
    input  logic                                 empty,
    input  logic                                 pop,
    input  logic [mscs_pkg::PIX_W-1:0]           start_x,
    input  logic [mscs_pkg::PIX_W-1:0]           start_y,
    input  logic [mscs_pkg::PIX_W-1:0]           end_x,
    input  logic [mscs_pkg::PIX_W-1:0]           end_y,
    input  logic                                 last_segment,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [mscs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mscs_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int                                   errors,
    output int                                   pending
);
    import mscs_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] sx;
        logic [PIX_W-1:0] sy;
        logic [PIX_W-1:0] ex;
        logic [PIX_W-1:0] ey;
        logic             last;
    } segment_t;

    segment_t segments_due[$];

    logic signed [SAMPLE_W-1:0] lvl_q;
    logic [ORG_W-1:0]           org_x_q;
    logic [ORG_W-1:0]           org_y_q;
    logic [SIZE_W-1:0]          width_q;
    logic [SIZE_W-1:0]          height_q;

    assign pending = segments_due.size();

    function automatic longint unsigned edge_fraction(longint a, longint b, longint lv);
        longint d;
        longint n;
        d = b - a;
        n = lv - a;
        if (d == 0)
            return longint'(1) << (FRAC_W - 1);
        if (d < 0)
        begin
            d = -d;
            n = -n;
        end
        if (n <= 0)
            return 0;
        if (n >= d)
            return longint'(1) << FRAC_W;
        return (longint'(n) << FRAC_W) / d;
    endfunction

    function automatic logic [PIX_W-1:0] to_pix(longint unsigned idx, longint unsigned frac,
                                                longint unsigned org, longint unsigned size);
        longint unsigned pos;
        longint unsigned v;
        pos = (idx << FRAC_W) + frac;
        v = org + ((pos * size + (64'd1 << (RND_SH - 1))) >> RND_SH);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    // edge pair of segment k for case c; ok low when the case has no such segment
    task automatic seg_edges(input logic [3:0] c, input int k, output edge_t s, output edge_t e,
                             output bit ok);
        ok = 1;
        s = EDGE_LEFT;
        e = EDGE_TOP;
        if (k == 1)
        begin
            ok = (c == 4'd5) || (c == 4'd10);
            if (c == 4'd5)
            begin
                s = EDGE_RIGHT;
                e = EDGE_BOTTOM;
            end
            else
            begin
                s = EDGE_LEFT;
                e = EDGE_BOTTOM;
            end
        end
        else
        begin
            case (c)
                4'd0, 4'd15: ok = 0;
                4'd1, 4'd14, 4'd5: begin s = EDGE_LEFT;  e = EDGE_TOP;    end
                4'd2, 4'd13, 4'd10: begin s = EDGE_TOP;  e = EDGE_RIGHT;  end
                4'd3, 4'd12:       begin s = EDGE_LEFT;  e = EDGE_RIGHT;  end
                4'd4, 4'd11:       begin s = EDGE_RIGHT; e = EDGE_BOTTOM; end
                4'd6, 4'd9:        begin s = EDGE_TOP;   e = EDGE_BOTTOM; end
                default:           begin s = EDGE_LEFT;  e = EDGE_BOTTOM; end
            endcase
        end
    endtask

    task automatic predict_cell();
        longint tl, tr, bl, br, lv;
        longint unsigned col, row;
        logic [3:0] cs;
        logic [PIX_W-1:0] px [4];
        logic [PIX_W-1:0] py [4];
        edge_t s, e;
        bit ok;
        segment_t sg;
        int n;
        tl = top_left;
        tr = top_right;
        bl = bottom_left;
        br = bottom_right;
        lv = lvl_q;
        col = cell_col;
        row = cell_row;
        if (missing_mask != 0)
            return;
        cs = {bl >= lv, br >= lv, tr >= lv, tl >= lv};
        px[EDGE_TOP]    = to_pix(col, edge_fraction(tl, tr, lv), org_x_q, width_q);
        py[EDGE_TOP]    = to_pix(row, 0, org_y_q, height_q);
        px[EDGE_RIGHT]  = to_pix(col + 1, 0, org_x_q, width_q);
        py[EDGE_RIGHT]  = to_pix(row, edge_fraction(tr, br, lv), org_y_q, height_q);
        px[EDGE_BOTTOM] = to_pix(col, edge_fraction(bl, br, lv), org_x_q, width_q);
        py[EDGE_BOTTOM] = to_pix(row + 1, 0, org_y_q, height_q);
        px[EDGE_LEFT]   = to_pix(col, 0, org_x_q, width_q);
        py[EDGE_LEFT]   = to_pix(row, edge_fraction(tl, bl, lv), org_y_q, height_q);
        n = 0;
        for (int k = 0; k < 2; k++)
        begin
            seg_edges(cs, k, s, e, ok);
            if (ok)
            begin
                sg.sx = px[s];
                sg.sy = py[s];
                sg.ex = px[e];
                sg.ey = py[e];
                sg.last = 0;
                segments_due.push_back(sg);
                n++;
            end
        end
        if (n > 0)
            segments_due[$].last = 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_q    <= '0;
            org_x_q  <= 12'd30;
            org_y_q  <= 12'd12;
            width_q  <= 20'd256;
            height_q <= 20'd256;
            errors   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ISO_LEVEL:   lvl_q    <= cfg_data[SAMPLE_W-1:0];
                    CFG_ORIGIN_X:    org_x_q  <= cfg_data[ORG_W-1:0];
                    CFG_ORIGIN_Y:    org_y_q  <= cfg_data[ORG_W-1:0];
                    CFG_CELL_WIDTH:  width_q  <= cfg_data[SIZE_W-1:0];
                    CFG_CELL_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (push && !full)
                predict_cell();
            if (pop && !empty)
            begin
                segment_t want;
                if (segments_due.size() == 0)
                begin
                    $error("segment popped with none expected");
                    errors <= errors + 1;
                end
                else
                begin
                    want = segments_due.pop_front();
                    if (start_x !== want.sx || start_y !== want.sy || end_x !== want.ex
                        || end_y !== want.ey || last_segment !== want.last)
                    begin
                        if (start_x !== want.sx)
                            $error("start_x expected %0d got %0d", want.sx, start_x);
                        if (start_y !== want.sy)
                            $error("start_y expected %0d got %0d", want.sy, start_y);
                        if (end_x !== want.ex)
                            $error("end_x expected %0d got %0d", want.ex, end_x);
                        if (end_y !== want.ey)
                            $error("end_y expected %0d got %0d", want.ey, end_y);
                        if (last_segment !== want.last)
                            $error("last_segment expected %0d got %0d", want.last,
                                   last_segment);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: verif/marching_squares_cell_segments_tb.sv
// Top of the marching-squares cell testbench: clock, reset, config phases, cell stimulus
// and pop back-pressure. Depends on mscs_pkg, the block and marching_squares_cell_segments_chk.
module marching_squares_cell_segments_tb;
    import mscs_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]    col;
        logic [IDX_W-1:0]    row;
        logic [SAMPLE_W-1:0] tl, tr, bl, br;
        logic [3:0]          miss;
    } cell_t;

    logic clk = 0;
    logic rst_n = 0;
    logic push = 0;
    logic full;
    logic [IDX_W-1:0] cell_col = '0;
    logic [IDX_W-1:0] cell_row = '0;
    logic signed [SAMPLE_W-1:0] top_left = '0;
    logic signed [SAMPLE_W-1:0] top_right = '0;
    logic signed [SAMPLE_W-1:0] bottom_left = '0;
    logic signed [SAMPLE_W-1:0] bottom_right = '0;
    logic [3:0] missing_mask = '0;
    logic empty;
    logic pop = 0;
    logic [PIX_W-1:0] start_x, start_y, end_x, end_y;
    logic last_segment;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int errors;
    int pending;

    logic signed [SAMPLE_W-1:0] level_now;
    bit push_quiet;
    bit pop_quiet;

    always #2 clk = ~clk;

    marching_squares_cell_segments i_dut (.*);
    marching_squares_cell_segments_chk i_chk (.*);

    function automatic int draw_gap(bit quiet);
        if (quiet)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // leaves cfg_valid high; the caller drops it after the last write of a group
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_ISO_LEVEL)
            level_now = val;
    endtask

    task automatic setup(logic [23:0] lv, logic [11:0] ox, logic [11:0] oy,
                         logic [19:0] cw, logic [19:0] ch);
        write_reg(CFG_ISO_LEVEL, lv);
        write_reg(CFG_ORIGIN_X, CFG_DATA_W'(ox));
        write_reg(CFG_ORIGIN_Y, CFG_DATA_W'(oy));
        write_reg(CFG_CELL_WIDTH, CFG_DATA_W'(cw));
        write_reg(CFG_CELL_HEIGHT, CFG_DATA_W'(ch));
        write_reg(CFG_IDX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom));
        cfg_valid <= 0;
    endtask

    task automatic send_cell(cell_t c);
        int gap;
        gap = draw_gap(push_quiet);
        if (gap > 0)
        begin
            push <= 0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1;
        cell_col     <= c.col;
        cell_row     <= c.row;
        top_left     <= c.tl;
        top_right    <= c.tr;
        bottom_left  <= c.bl;
        bottom_right <= c.br;
        missing_mask <= c.miss;
        do @(posedge clk); while (full);
    endtask

    // near the level most of the time so crossings land inside the cell
    function automatic logic [SAMPLE_W-1:0] pick_sample(bit hi);
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return SAMPLE_W'($urandom);
        if (r < 6)
            return SAMPLE_W'(level_now + (hi ? $urandom_range(0, 300)
                                             : -1 - $urandom_range(0, 300)));
        return SAMPLE_W'(level_now + (hi ? $urandom_range(0, 3) : -1 - $urandom_range(0, 3)));
    endfunction

    function automatic cell_t random_cell();
        cell_t c;
        logic [3:0] cs;
        cs = 4'($urandom);
        c.col = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 63));
        c.row = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 63));
        c.tl = pick_sample(cs[0]);
        c.tr = pick_sample(cs[1]);
        c.br = pick_sample(cs[2]);
        c.bl = pick_sample(cs[3]);
        case ($urandom_range(0, 11))
            0: c.tr = c.tl;
            1: c.bl = c.br;
            default: ;
        endcase
        c.miss = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
        return c;
    endfunction

    task automatic settle();
        push <= 0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic directed_cells();
        cell_t c;
        for (int k = 0; k < 16; k++)
        begin
            c.col = (k & 1) ? 12'hFFF : 12'h000;
            c.row = (k & 2) ? 12'hFFF : 12'h000;
            c.tl = k[0] ? 24'h7FFFFF : 24'h800000;
            c.tr = k[1] ? 24'h000005 : 24'hFFFFFD;
            c.br = k[2] ? 24'h000000 : 24'hFFFFFF;
            c.bl = k[3] ? 24'h123456 : 24'hEDCBA9;
            c.miss = 0;
            send_cell(c);
        end
        // flat edges: top and left sides, then left and right sides
        c = '{12'd3, 12'd4, 24'd7, 24'd7, 24'd7, 24'hFFFFF0, 4'd0};
        send_cell(c);
        c = '{12'd3, 12'd4, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 4'd0};
        send_cell(c);
        for (int b = 0; b < 4; b++)
        begin
            c = '{12'd1, 12'd1, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 4'(1 << b)};
            send_cell(c);
        end
        c.miss = 4'hF;
        send_cell(c);
    endtask

    initial
    begin
        #4000000;
        $display("marching_squares_cell_segments_tb NOT OK");
        $finish;
    end

    initial
    begin
        pop_quiet = 0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            stall = draw_gap(pop_quiet);
            if (stall > 0)
            begin
                pop <= 0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1;
            do @(posedge clk); while (empty);
        end
    end

    initial
    begin
        level_now = 0;
        push_quiet = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        setup(24'd0, 12'd30, 12'd12, 20'd256, 20'd256);
        directed_cells();
        for (int ph = 0; ph < 8; ph++)
        begin
            settle();
            case (ph)
                0: setup(24'd0, 12'd30, 12'd12, 20'd256, 20'd256);
                1: setup(24'h800000, 12'd0, 12'd0, 20'd0, 20'd0);
                2: setup(24'h7FFFFF, 12'hFFF, 12'hFFF, 20'hFFFFF, 20'hFFFFF);
                3: setup(24'($urandom), 12'($urandom), 12'($urandom), 20'($urandom),
                         20'($urandom));
                default: setup(24'($urandom_range(0, 2000) - 1000),
                               12'($urandom_range(0, 200)), 12'($urandom_range(0, 200)),
                               20'($urandom_range(0, 4096)), 20'($urandom_range(0, 4096)));
            endcase
            push_quiet = ($urandom_range(0, 3) == 0);
            pop_quiet  = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 235; i++)
                send_cell(random_cell());
        end
        push <= 0;
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("marching_squares_cell_segments_tb OK");
        else
            $display("marching_squares_cell_segments_tb NOT OK");
        $finish;
    end

endmodule
